// ===== hw/rtl/brd_pkg.sv =====
// brd_pkg: types, codes and constants of the boundary recipe decoder
// used by every module under hw/rtl; depends on nothing

package brd_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int SEEN_W       = 18;
    localparam int PADDR_W      = 3;

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // configuration register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_PLAIN_SIZE   = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_MIN_BOUNDARY = 3'd4;

    localparam logic [15:0] PLAIN_SIZE_RST   = 16'd1;
    localparam logic [7:0]  MIN_BOUNDARY_RST = 8'd48;

    localparam logic [7:0] FORM_SPARSE = 8'd0;
    localparam logic [7:0] FORM_BITMAP = 8'd1;

    typedef enum logic [2:0] {
        PH_FORM,
        PH_CNT_HI,
        PH_CNT_LO,
        PH_ENT_HI,
        PH_ENT_LO,
        PH_BITMAP,
        PH_IDLE
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_FORM,
        ERR_LENGTH,
        ERR_RANGE,
        ERR_ORDER,
        ERR_BIT_ZERO,
        ERR_PADDING
    } err_code_t;

    typedef struct packed {
        logic [7:0] recipe_byte;
        logic       last_byte;
    } recipe_item_t;

    typedef struct packed {
        logic        is_verdict;
        logic [15:0] boundary_pos;
        logic        recipe_ok;
        err_code_t   error_code;
        logic        run_last;
    } result_item_t;

    // results that one accepted byte leaves for the emitter
    typedef struct packed {
        logic [7:0]  bmask;
        logic [15:0] base;
        logic        vpend;
        logic        vok;
        err_code_t   verr;
    } emit_load_t;

endpackage

// ===== hw/rtl/brd_decode.sv =====
// brd_decode: recipe state registers and the per-byte decode step
// depends on brd_pkg

module brd_decode
    import brd_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  recipe_item_t item,
    input  logic [15:0]  plain_size,
    input  logic [7:0]   min_boundary,
    output emit_load_t   load
);

    localparam logic [16:0] POS_LIMIT = 17'(1) << POS_BITS;

    phase_t              phase_reg, phase_next;
    logic                bitmap_form_reg, bitmap_form_next;
    logic [15:0]         entry_count_reg, entry_count_next;
    logic [SEEN_W-1:0]   bytes_seen_reg, bytes_seen_next;
    logic [7:0]          high_half_reg, high_half_next;
    logic [POS_BITS-1:0] previous_pos_reg, previous_pos_next;
    err_code_t           first_error_reg, first_error_next;

    logic [7:0]        b;
    logic [13:0]       nbytes;
    logic [SEEN_W-1:0] idx_m1;
    logic [15:0]       v;
    logic [15:0]       p;
    logic [7:0]        emask;
    logic [15:0]       ebase;
    logic              bad_len;
    err_code_t         err_v;
    err_code_t         bit_fail;

    assign b      = item.recipe_byte;
    assign nbytes = 14'((17'(plain_size) + 17'd7) >> 3);
    assign idx_m1 = bytes_seen_reg - SEEN_W'(1);
    assign v      = {high_half_reg, b};

    always_comb
    begin
        phase_next        = phase_reg;
        bitmap_form_next  = bitmap_form_reg;
        entry_count_next  = entry_count_reg;
        high_half_next    = high_half_reg;
        previous_pos_next = previous_pos_reg;
        first_error_next  = first_error_reg;
        emask             = '0;
        ebase             = '0;
        p                 = '0;
        bit_fail          = ERR_NONE;
        bytes_seen_next   = (bytes_seen_reg != SEEN_MAX) ? bytes_seen_reg + SEEN_W'(1)
                                                         : bytes_seen_reg;
        case (phase_reg)
            PH_FORM:
            begin
                if (b == FORM_SPARSE)
                begin
                    bitmap_form_next = 1'b0;
                    phase_next       = PH_CNT_HI;
                end
                else if (b == FORM_BITMAP)
                begin
                    bitmap_form_next = 1'b1;
                    phase_next       = PH_BITMAP;
                end
                else
                begin
                    first_error_next = ERR_FORM;
                    phase_next       = PH_IDLE;
                end
            end
            PH_CNT_HI:
            begin
                high_half_next = b;
                phase_next     = PH_CNT_LO;
            end
            PH_CNT_LO:
            begin
                entry_count_next = v;
                phase_next       = (v != 16'd0) ? PH_ENT_HI : PH_IDLE;
            end
            PH_ENT_HI:
            begin
                high_half_next = b;
                phase_next     = PH_ENT_LO;
            end
            PH_ENT_LO:
            begin
                if (first_error_reg == ERR_NONE)
                begin
                    if (v < 16'(min_boundary) || v >= plain_size || 17'(v) >= POS_LIMIT)
                        first_error_next = ERR_RANGE;
                    else if (v <= 16'(previous_pos_reg))
                        first_error_next = ERR_ORDER;
                    else
                    begin
                        emask             = 8'd1;
                        ebase             = v;
                        previous_pos_next = POS_BITS'(v);
                    end
                end
                // entries done once (seen - 3) / 2 reaches the count
                phase_next = (((bytes_seen_next - SEEN_W'(3)) >> 1) >= SEEN_W'(entry_count_reg))
                             ? PH_IDLE : PH_ENT_HI;
            end
            PH_BITMAP:
            begin
                if (bytes_seen_reg != '0 && idx_m1 < SEEN_W'(nbytes))
                begin
                    ebase = {idx_m1[12:0], 3'b000};
                    // bits in order; the first failing set bit stops the rest
                    for (int i = 0; i < 8; i++)
                    begin
                        p        = {idx_m1[12:0], 3'(i)};
                        bit_fail = ERR_NONE;
                        if (p == 16'd0)
                            bit_fail = ERR_BIT_ZERO;
                        else if (p >= plain_size)
                            bit_fail = ERR_PADDING;
                        else if (p < 16'(min_boundary) || 17'(p) >= POS_LIMIT)
                            bit_fail = ERR_RANGE;
                        if (b[i] && first_error_next == ERR_NONE)
                        begin
                            if (bit_fail != ERR_NONE)
                                first_error_next = bit_fail;
                            else
                                emask[i] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        err_v   = first_error_next;
        bad_len = 1'b0;
        if (bitmap_form_next)
            bad_len = bytes_seen_next != SEEN_W'(nbytes) + SEEN_W'(1);
        else
            bad_len = bytes_seen_next < SEEN_W'(3)
                      || bytes_seen_next != SEEN_W'({entry_count_next, 1'b0}) + SEEN_W'(3);
        // length mismatch overrides all but a bad form byte
        if (err_v != ERR_FORM && bad_len)
            err_v = ERR_LENGTH;
    end

    assign load.bmask = emask;
    assign load.base  = ebase;
    assign load.vpend = item.last_byte;
    assign load.vok   = (err_v == ERR_NONE);
    assign load.verr  = err_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_FORM;
            bitmap_form_reg  <= 1'b0;
            entry_count_reg  <= '0;
            bytes_seen_reg   <= '0;
            high_half_reg    <= '0;
            previous_pos_reg <= '0;
            first_error_reg  <= ERR_NONE;
        end
        else if (accept)
        begin
            if (item.last_byte)
            begin
                phase_reg        <= PH_FORM;
                bitmap_form_reg  <= 1'b0;
                entry_count_reg  <= '0;
                bytes_seen_reg   <= '0;
                high_half_reg    <= '0;
                previous_pos_reg <= '0;
                first_error_reg  <= ERR_NONE;
            end
            else
            begin
                phase_reg        <= phase_next;
                bitmap_form_reg  <= bitmap_form_next;
                entry_count_reg  <= entry_count_next;
                bytes_seen_reg   <= bytes_seen_next;
                high_half_reg    <= high_half_next;
                previous_pos_reg <= previous_pos_next;
                first_error_reg  <= first_error_next;
            end
        end
    end

endmodule

// ===== hw/rtl/brd_emit.sv =====
// brd_emit: pending-result buffer and output register, one result per cycle while result_stall is low
// depends on brd_pkg

module brd_emit
    import brd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  emit_load_t   load,
    output logic         busy,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result
);

    logic [7:0]   bmask_reg, bmask_next;
    logic [15:0]  base_reg;
    logic         vpend_reg, vpend_next;
    logic         vok_reg;
    err_code_t    verr_reg;
    logic         out_valid_reg, out_valid_next;
    result_item_t out_reg, out_next;

    logic         take;
    logic         has_items;
    logic         single;
    logic [7:0]   low_bit;
    logic [7:0]   rest;
    logic [2:0]   low_idx;

    assign take      = !out_valid_reg || !result_stall;
    assign has_items = (bmask_reg != '0) || vpend_reg;
    assign low_bit   = bmask_reg & (~bmask_reg + 8'd1);
    assign rest      = bmask_reg & ~low_bit;
    assign single    = (bmask_reg == '0) ? vpend_reg : (rest == '0 && !vpend_reg);

    // a new byte can load only when nothing is pending or the last pending result leaves now
    assign busy = has_items && !(single && take);

    always_comb
    begin
        low_idx = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (bmask_reg[i])
                low_idx = 3'(i);
        end
    end

    always_comb
    begin
        bmask_next     = bmask_reg;
        vpend_next     = vpend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (take)
        begin
            out_valid_next = has_items;
            if (bmask_reg != '0)
            begin
                out_next.is_verdict   = 1'b0;
                out_next.boundary_pos = base_reg | 16'(low_idx);
                out_next.recipe_ok    = 1'b0;
                out_next.error_code   = ERR_NONE;
                out_next.run_last     = (rest == '0) && !vpend_reg;
                bmask_next            = rest;
            end
            else
            begin
                out_next.is_verdict   = 1'b1;
                out_next.boundary_pos = '0;
                out_next.recipe_ok    = vok_reg;
                out_next.error_code   = verr_reg;
                out_next.run_last     = 1'b1;
                vpend_next            = 1'b0;
            end
        end
        if (accept)
        begin
            bmask_next = load.bmask;
            vpend_next = load.vpend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bmask_reg     <= '0;
            vpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bmask_reg     <= bmask_next;
            vpend_reg     <= vpend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            base_reg <= load.base;
            vok_reg  <= load.vok;
            verr_reg <= load.verr;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== hw/rtl/boundary_recipe_decoder.sv =====
// boundary_recipe_decoder: top level, configuration registers and the two stages
// depends on brd_pkg, brd_decode, brd_emit
//
// usage:
//   recipe channel (recipe_valid / recipe_stall / recipe) takes one recipe byte
//   per request, last_byte set on the final byte of a recipe. result channel
//   (result_valid / result_stall / result) gives boundary items in order, then
//   one verdict item after the last byte; run_last marks the last result of a byte.
//   plain_size sits at byte address 0, min_boundary at 4; write them only while idle.
//   a taken byte's results wait in the pending-result buffer, then pass to the output register.
//   throughput: one byte per cycle while result_stall is low and each byte gives at
//   most one result; a byte that gives more results (boundaries plus a verdict if
//   last) holds recipe_stall until its last result leaves, as the single output
//   register sends one result per cycle while result_stall is low.
//   reset clears the decode state, the pending results and result_valid, and
//   loads plain_size 1 and min_boundary 48; no clearing pass is needed.
//   when result_stall is high the result holds, the pending results wait, and
//   recipe_stall rises once the next byte has nowhere to put its results.

module boundary_recipe_decoder
    import brd_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               recipe_valid,
    output logic               recipe_stall,
    input  recipe_item_t       recipe,
    output logic               result_valid,
    input  logic               result_stall,
    output result_item_t       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] plain_size_reg;
    logic [7:0]  min_boundary_reg;
    logic        cfg_write;
    logic        accept;
    logic        busy;
    emit_load_t  load;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // register select by word address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_size_reg   <= PLAIN_SIZE_RST;
            min_boundary_reg <= MIN_BOUNDARY_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ADDR_MIN_BOUNDARY[2])
                min_boundary_reg <= pwdata[7:0];
            else
                plain_size_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == ADDR_MIN_BOUNDARY[2])
            prdata = {24'd0, min_boundary_reg};
        else
            prdata = {16'd0, plain_size_reg};
    end

    assign recipe_stall = busy;
    assign accept       = recipe_valid && !busy;

    brd_decode #(
        .POS_BITS (POS_BITS)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (recipe),
        .plain_size   (plain_size_reg),
        .min_boundary (min_boundary_reg),
        .load         (load)
    );

    brd_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .load         (load),
        .busy         (busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== hw/rtl/brd_checker.sv =====
// brd_checker: port-level assertions for boundary_recipe_decoder, bound to the top
// depends on brd_pkg

module brd_checker
    import brd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         result_valid,
    input logic         result_stall,
    input result_item_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_verdict |-> result.run_last && result.boundary_pos == 16'd0)
        else $error("verdict not closing its byte");

    a_boundary_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.is_verdict |-> !result.recipe_ok
            && result.error_code == ERR_NONE)
        else $error("boundary item carries verdict fields");

    a_verdict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_verdict |-> result.recipe_ok == (result.error_code == ERR_NONE))
        else $error("verdict ok flag disagrees with error code");

endmodule

bind boundary_recipe_decoder brd_checker u_brd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== tb/testbench.sv =====
// testbench for boundary_recipe_decoder: random and directed recipes, results checked in order
// holds its own recipe decoder model in a small scoreboard class; depends on brd_pkg and the rtl

module testbench;
    import brd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    class recipe_checker;
        logic [15:0]  plain_size;
        logic [7:0]   min_boundary;
        phase_t       ph;
        logic         bitmap_form;
        logic [15:0]  entry_count;
        logic [17:0]  bytes_seen;
        logic [7:0]   high_half;
        logic [15:0]  previous_pos;
        err_code_t    first_error;
        result_item_t pending_results[$];
        int           mismatches;
        int           boundaries_checked;
        int           verdicts_checked;

        function new();
            plain_size = PLAIN_SIZE_RST;
            min_boundary = MIN_BOUNDARY_RST;
            mismatches = 0;
            boundaries_checked = 0;
            verdicts_checked = 0;
            restart();
        endfunction

        function void restart();
            ph = PH_FORM;
            bitmap_form = 1'b0;
            entry_count = '0;
            bytes_seen = '0;
            high_half = '0;
            previous_pos = '0;
            first_error = ERR_NONE;
        endfunction

        function void expect_result(result_item_t r);
            pending_results = {pending_results, r};
        endfunction

        // work out the results one accepted request causes
        function void take_byte(logic [7:0] b, logic fin);
            result_item_t found[9];
            result_item_t r;
            int unsigned  idx;
            int unsigned  nbytes;
            int unsigned  p;
            int unsigned  seen;
            logic [15:0]  v;
            err_code_t    err;
            logic         bad_len;
            int           k;
            k = 0;
            r = '0;
            idx = bytes_seen;
            nbytes = (32'(plain_size) + 7) / 8;
            if (bytes_seen != SEEN_MAX)
                bytes_seen++;
            seen = bytes_seen;
            case (ph)
                PH_FORM:
                begin
                    if (b == FORM_SPARSE)
                    begin
                        bitmap_form = 1'b0;
                        ph = PH_CNT_HI;
                    end
                    else if (b == FORM_BITMAP)
                    begin
                        bitmap_form = 1'b1;
                        ph = PH_BITMAP;
                    end
                    else
                    begin
                        first_error = ERR_FORM;
                        ph = PH_IDLE;
                    end
                end
                PH_CNT_HI:
                begin
                    high_half = b;
                    ph = PH_CNT_LO;
                end
                PH_CNT_LO:
                begin
                    entry_count = {high_half, b};
                    ph = (entry_count != 0) ? PH_ENT_HI : PH_IDLE;
                end
                PH_ENT_HI:
                begin
                    high_half = b;
                    ph = PH_ENT_LO;
                end
                PH_ENT_LO:
                begin
                    v = {high_half, b};
                    if (first_error == ERR_NONE)
                    begin
                        if (v < min_boundary || v >= plain_size)
                            first_error = ERR_RANGE;
                        else if (v <= previous_pos)
                            first_error = ERR_ORDER;
                        else
                        begin
                            r.boundary_pos = v;
                            found[k] = r;
                            k++;
                            previous_pos = v;
                        end
                    end
                    ph = ((seen - 3) / 2 >= 32'(entry_count)) ? PH_IDLE : PH_ENT_HI;
                end
                PH_BITMAP:
                begin
                    // bytes past the bitmap length are only counted
                    if (idx >= 1 && idx - 1 < nbytes)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            p = (idx - 1) * 8 + i;
                            if (b[i] && first_error == ERR_NONE)
                            begin
                                if (p == 0)
                                    first_error = ERR_BIT_ZERO;
                                else if (p >= plain_size)
                                    first_error = ERR_PADDING;
                                else if (p < min_boundary)
                                    first_error = ERR_RANGE;
                                else
                                begin
                                    r.boundary_pos = 16'(p);
                                    found[k] = r;
                                    k++;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (fin)
            begin
                err = first_error;
                // a length mismatch overrides any error but a bad form byte
                if (err != ERR_FORM)
                begin
                    if (bitmap_form)
                        bad_len = seen != 1 + nbytes;
                    else
                        bad_len = seen < 3 || seen != 3 + 2 * 32'(entry_count);
                    if (bad_len)
                        err = ERR_LENGTH;
                end
                r = '0;
                r.is_verdict = 1'b1;
                r.recipe_ok = (err == ERR_NONE);
                r.error_code = err;
                found[k] = r;
                k++;
                restart();
            end
            if (k > 0)
                found[k - 1].run_last = 1'b1;
            for (int i = 0; i < k; i++)
                expect_result(found[i]);
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;
            if (got.is_verdict)
                verdicts_checked++;
            else
                boundaries_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: verdict %0d pos %0d ok %0d err %0d last %0d",
                             got.is_verdict, got.boundary_pos, got.recipe_ok,
                             got.error_code, got.run_last);
                return;
            end
            want = pending_results.pop_front();
            if (got.is_verdict !== want.is_verdict || got.boundary_pos !== want.boundary_pos ||
                got.recipe_ok !== want.recipe_ok || got.error_code !== want.error_code ||
                got.run_last !== want.run_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want v%0d p%0d ok%0d e%0d l%0d, got v%0d p%0d ok%0d e%0d l%0d",
                             want.is_verdict, want.boundary_pos, want.recipe_ok,
                             want.error_code, want.run_last, got.is_verdict,
                             got.boundary_pos, got.recipe_ok, got.error_code, got.run_last);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               recipe_valid = 1'b0;
    logic               recipe_stall;
    recipe_item_t       recipe = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    result_item_t       result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    recipe_checker rc;
    logic [7:0]    recipe_bytes[$];
    int            send_idle_pct = 22;
    int            recv_idle_pct = 70;
    int            bytes_sent = 0;
    int            cycle_count = 0;
    int            set_plain[8] = '{20, 64, 200, 1, 65535, 0, 37, 130};
    int            set_min[8] = '{3, 1, 48, 48, 255, 0, 5, 16};

    boundary_recipe_decoder uut (
        .clk(clk),
        .rst_n(rst_n),
        .recipe_valid(recipe_valid),
        .recipe_stall(recipe_stall),
        .recipe(recipe),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            rc.check_result(result);
    end

    function automatic void append_byte(input logic [7:0] b);
        recipe_bytes = {recipe_bytes, b};
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            recipe_valid <= 1'b0;
            recipe <= recipe_item_t'(9'($urandom));
            @(negedge clk);
        end
        recipe_valid <= 1'b1;
        recipe.recipe_byte <= b;
        recipe.last_byte <= fin;
        @(posedge clk);
        while (recipe_stall)
            @(posedge clk);
        rc.take_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_recipe();
        for (int i = 0; i < recipe_bytes.size(); i++)
            send_byte(recipe_bytes[i], i == recipe_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        recipe_valid <= 1'b0;
        while (rc.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_setting(input int ps, input int mb);
        wait_drained();
        // a bitmap byte past the end can still be in flight with nothing expected
        repeat (4) @(posedge clk);
        reg_write(ADDR_PLAIN_SIZE, 32'(ps));
        reg_write(ADDR_MIN_BOUNDARY, 32'(mb));
        rc.plain_size = 16'(ps);
        rc.min_boundary = 8'(mb);
    endtask

    // mostly well-formed recipes with random content, the rest broken or noise
    task automatic build_recipe();
        int         kind;
        int         ps;
        int         mb;
        int         n;
        int         count;
        int         gap;
        int         cur;
        int         v;
        int         nb;
        int         len;
        int         p;
        logic [7:0] bv;
        recipe_bytes.delete();
        ps = rc.plain_size;
        mb = rc.min_boundary;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            count = ($urandom_range(19) == 0) ? $urandom_range(65535) : n;
            append_byte(FORM_SPARSE);
            append_byte(8'(count >> 8));
            append_byte(8'(count));
            gap = (ps - 1 - mb) / (n + 1);
            if (gap < 1)
                gap = 1;
            cur = mb - 1;
            for (int i = 0; i < n; i++)
            begin
                cur = cur + 1 + int'($urandom_range(gap));
                if (i == n - 1 && $urandom_range(7) == 0)
                    cur = ps - 1;
                v = cur;
                if ($urandom_range(11) == 0)
                    v = $urandom_range(65535);
                append_byte(8'(v >> 8));
                append_byte(8'(v));
            end
        end
        else if (kind < 75)
        begin
            nb = (ps + 7) / 8;
            len = (nb > 40) ? $urandom_range(12) : nb;
            append_byte(FORM_BITMAP);
            for (int i = 0; i < len; i++)
            begin
                bv = ($urandom_range(5) == 0) ? 8'hff : 8'($urandom);
                for (int j = 0; j < 8; j++)
                begin
                    p = i * 8 + j;
                    if (p == 0)
                    begin
                        if ($urandom_range(5) != 0)
                            bv[j] = 1'b0;
                    end
                    else if (p >= ps)
                    begin
                        if ($urandom_range(5) != 0)
                            bv[j] = 1'b0;
                    end
                    else if (p < mb && $urandom_range(3) != 0)
                        bv[j] = 1'b0;
                end
                append_byte(bv);
            end
        end
        else if (kind < 85)
        begin
            append_byte(8'($urandom_range(2, 255)));
            repeat ($urandom_range(3))
                append_byte(8'($urandom));
        end
        else
        begin
            case ($urandom_range(2))
                0: append_byte(FORM_SPARSE);
                1: append_byte(FORM_BITMAP);
                default: append_byte(8'($urandom));
            endcase
            repeat ($urandom_range(7))
                append_byte(8'($urandom));
        end
        // truncate or pad a well-formed recipe now and then
        if (kind < 75 && $urandom_range(9) == 0)
        begin
            if ($urandom_range(1) == 1 && recipe_bytes.size() > 1)
                void'(recipe_bytes.pop_back());
            else
                repeat ($urandom_range(1, 3))
                    append_byte(8'($urandom));
        end
    endtask

    initial
    begin
        int start_bytes;
        rc = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values: bad form byte, then an empty sparse list
        recipe_bytes = '{8'h02};
        send_recipe();
        recipe_bytes = '{FORM_SPARSE, 8'h00, 8'h00};
        send_recipe();

        for (int s = 0; s < 8; s++)
        begin
            if (s < 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 70;
            end
            else if (s < 6)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(set_plain[s], set_min[s]);
            if (s == 0)
            begin
                // short sparse recipe, two good boundaries, bit zero, padding, bad form byte
                recipe_bytes = '{FORM_SPARSE};
                send_recipe();
                recipe_bytes = '{FORM_SPARSE, 8'h00, 8'h02, 8'h00, 8'h05, 8'h00, 8'h13};
                send_recipe();
                recipe_bytes = '{FORM_BITMAP, 8'h01, 8'h00, 8'h00};
                send_recipe();
                recipe_bytes = '{FORM_BITMAP, 8'h08, 8'hff, 8'hff};
                send_recipe();
                recipe_bytes = '{8'hff, 8'h00};
                send_recipe();
            end
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < 46)
            begin
                build_recipe();
                send_recipe();
                if ($urandom_range(24) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("run covered %0d recipe bytes over 8 register settings and three idle mixes",
                 bytes_sent);
        $display("checked %0d boundary results and %0d verdicts, %0d mismatches",
                 rc.boundaries_checked, rc.verdicts_checked, rc.mismatches);
        if (rc.mismatches == 0 && rc.pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/brd_pkg.sv
hw/rtl/brd_decode.sv
hw/rtl/brd_emit.sv
hw/rtl/boundary_recipe_decoder.sv
hw/rtl/brd_checker.sv
tb/testbench.sv
